FILE: sv/wws_pkg.sv
// shared types and constants of the weighted window subsampler
package wws_pkg;

   localparam int PIX_W     = 16;  // pixel, signed q8.8
   localparam int VAL_W     = 32;  // result value, 8 fraction bits
   localparam int OCOL_W    = 10;
   localparam int OROW_W    = 10;
   localparam int KREG_W    = 4;   // kernel and stride registers
   localparam int DIM_REG_W = 11;  // image size registers
   localparam int COEF_W    = 16;  // weight and bias, signed q8.8
   localparam int FRAC_BITS = 8;
   localparam int STRIDE_MAX = 15;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   localparam logic [KREG_W-1:0]    RST_KERNEL = 4'd2;
   localparam logic [KREG_W-1:0]    RST_STRIDE = 4'd2;
   localparam logic [DIM_REG_W-1:0] RST_DIM    = 11'd1024;
   localparam logic [COEF_W-1:0]    RST_WEIGHT = 16'd256;
   localparam logic [COEF_W-1:0]    RST_BIAS   = 16'd0;

   typedef enum logic [2:0] {
      REG_KERNEL_W = 3'd0,
      REG_KERNEL_H = 3'd1,
      REG_STRIDE_W = 3'd2,
      REG_STRIDE_H = 3'd3,
      REG_IMAGE_W  = 3'd4,
      REG_IMAGE_H  = 3'd5,
      REG_WEIGHT   = 3'd6,
      REG_BIAS     = 3'd7
   } wws_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAIN,
      ST_SCALE,
      ST_BIAS
   } wws_state_type;

   // raw geometry registers as written
   typedef struct packed {
      logic [KREG_W-1:0]    kernel_w;
      logic [KREG_W-1:0]    kernel_h;
      logic [KREG_W-1:0]    stride_w;
      logic [KREG_W-1:0]    stride_h;
      logic [DIM_REG_W-1:0] image_width;
      logic [DIM_REG_W-1:0] image_height;
   } wws_geom_type;

   // output tag of one window
   typedef struct packed {
      logic [OCOL_W-1:0] ox;
      logic [OROW_W-1:0] oy;
      logic              last;
   } wws_meta_type;

endpackage

FILE: sv/wws_if.sv
// valid/ready channel interfaces for pixels in and results out
interface wws_req_if import wws_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface wws_rsp_if import wws_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;
   logic [OCOL_W-1:0]       out_col;
   logic [OROW_W-1:0]       out_row;
   logic                    last_of_plane;

   modport source (output valid, output value, output out_col, output out_row,
                   output last_of_plane, input ready);
   modport sink   (input valid, input value, input out_col, input out_row,
                   input last_of_plane, output ready);
endinterface

FILE: sv/wws_ram.sv
// generic simple dual port ram, registered read
module wws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/wws_geom.sv
// pixel position tracking, stride phase and window detection
module wws_geom import wws_pkg::*; #(
   parameter int MAX_KERNEL = 8,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int COL_BITS  = $clog2(MAX_WIDTH),
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT),
   localparam int KB        = $clog2(MAX_KERNEL + 1),
   localparam int SLOT_BITS = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wws_geom_type         geom,
   input  logic                 geom_clr,
   input  logic                 accept,
   output logic                 hit,
   output wws_meta_type         meta,
   output logic [COL_BITS-1:0]  x0,
   output logic [SLOT_BITS-1:0] top_slot,
   output logic [SLOT_BITS-1:0] wr_slot,
   output logic [COL_BITS-1:0]  wr_col,
   output logic [KB-1:0]        kw,
   output logic [KB-1:0]        kh
);

   localparam int MB = (COL_BITS > ROW_BITS) ? COL_BITS + 2 : ROW_BITS + 2;
   localparam int DB = (MB > DIM_REG_W + 1) ? MB : DIM_REG_W + 1;

   function automatic logic [DB-1:0] clamp_dim(input logic [DB-1:0] v,
                                               input logic [DB-1:0] hi);
      logic [DB-1:0] r;
      if (v == '0) r = DB'(1);
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [KREG_W-1:0]    cph_ff, cph_in, rph_ff, rph_in;
   logic [OCOL_W-1:0]    ox_ff, ox_in;
   logic [OROW_W-1:0]    oy_ff, oy_in;

   logic [DB-1:0] kw_d, kh_d, sw_d, sh_d, w_d, h_d;
   logic [DB-1:0] c_d, r_d, nc_d, nr_d, sl_d, khm1_d, top_d;
   logic [KREG_W-1:0] sw_m1, sh_m1;
   logic col_end, row_end;

   always_comb begin
      kw_d = clamp_dim(DB'(geom.kernel_w), DB'(MAX_KERNEL));
      kh_d = clamp_dim(DB'(geom.kernel_h), DB'(MAX_KERNEL));
      sw_d = clamp_dim(DB'(geom.stride_w), DB'(STRIDE_MAX));
      sh_d = clamp_dim(DB'(geom.stride_h), DB'(STRIDE_MAX));
      w_d  = clamp_dim(DB'(geom.image_width), DB'(MAX_WIDTH));
      h_d  = clamp_dim(DB'(geom.image_height), DB'(MAX_HEIGHT));
      sw_m1 = KREG_W'(sw_d - DB'(1));
      sh_m1 = KREG_W'(sh_d - DB'(1));
      c_d  = DB'(col_ff);
      r_d  = DB'(row_ff);
   end

   // window detection for the pixel at the current position
   always_comb begin
      hit = ((c_d + DB'(1)) >= kw_d) && ((r_d + DB'(1)) >= kh_d) &&
            (cph_ff == '0) && (rph_ff == '0);
      meta.ox   = ox_ff;
      meta.oy   = oy_ff;
      meta.last = ((c_d + DB'(1) + sw_d) > w_d) && ((r_d + DB'(1) + sh_d) > h_d);
      x0     = COL_BITS'(c_d + DB'(1) - kw_d);
      sl_d   = DB'(slot_ff);
      khm1_d = kh_d - DB'(1);
      if (sl_d >= khm1_d) begin
         top_d = sl_d - khm1_d;
      end else begin
         top_d = sl_d + DB'(MAX_KERNEL) - khm1_d;
      end
      top_slot = SLOT_BITS'(top_d);
      wr_slot  = slot_ff;
      wr_col   = col_ff;
      kw       = KB'(kw_d);
      kh       = KB'(kh_d);
   end

   // position and phase after this pixel
   always_comb begin
      col_end = (c_d + DB'(1)) >= w_d;
      row_end = (r_d + DB'(1)) >= h_d;
      nc_d    = col_end ? '0 : c_d + DB'(1);
      nr_d    = row_end ? '0 : r_d + DB'(1);
      col_in  = COL_BITS'(nc_d);
      row_in  = row_ff;
      slot_in = slot_ff;
      cph_in  = cph_ff;
      ox_in   = ox_ff;
      rph_in  = rph_ff;
      oy_in   = oy_ff;

      if ((nc_d + DB'(1)) == kw_d) begin
         cph_in = '0;
         ox_in  = '0;
      end else if ((nc_d + DB'(1)) > kw_d) begin
         if (cph_ff == sw_m1) begin
            cph_in = '0;
            ox_in  = ox_ff + OCOL_W'(1);
         end else begin
            cph_in = cph_ff + KREG_W'(1);
         end
      end

      if (col_end) begin
         row_in = ROW_BITS'(nr_d);
         if (row_end || (slot_ff == SLOT_BITS'(MAX_KERNEL - 1))) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + SLOT_BITS'(1);
         end
         if ((nr_d + DB'(1)) == kh_d) begin
            rph_in = '0;
            oy_in  = '0;
         end else if ((nr_d + DB'(1)) > kh_d) begin
            if (rph_ff == sh_m1) begin
               rph_in = '0;
               oy_in  = oy_ff + OROW_W'(1);
            end else begin
               rph_in = rph_ff + KREG_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || geom_clr) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
         cph_ff  <= '0;
         ox_ff   <= '0;
         rph_ff  <= '0;
         oy_ff   <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
         cph_ff  <= cph_in;
         ox_ff   <= ox_in;
         rph_ff  <= rph_in;
         oy_ff   <= oy_in;
      end
   end

endmodule

FILE: sv/wws_accum.sv
// window sequencer with one shared adder, scale multiplier and result register
module wws_accum import wws_pkg::*; #(
   parameter int MAX_KERNEL = 8,
   parameter int MAX_WIDTH  = 1024,
   localparam int COL_BITS  = $clog2(MAX_WIDTH),
   localparam int KB        = $clog2(MAX_KERNEL + 1),
   localparam int SLOT_BITS = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
   localparam int SUM_BITS  = PIX_W + 2 * SLOT_BITS,
   localparam int PROD_BITS = SUM_BITS + COEF_W,
   localparam int ACC_BITS  = PROD_BITS - FRAC_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  wws_meta_type                  meta_in,
   input  logic [COL_BITS-1:0]           x0,
   input  logic [SLOT_BITS-1:0]          top_slot,
   input  logic [KB-1:0]                 kw,
   input  logic [KB-1:0]                 kh,
   input  logic signed [COEF_W-1:0]      weight,
   input  logic signed [COEF_W-1:0]      bias,
   output logic                          rd_en,
   output logic [SLOT_BITS+COL_BITS-1:0] rd_addr,
   input  logic signed [PIX_W-1:0]       rd_data,
   output logic                          busy,
   wws_rsp_if.source                     rsp
);

   wws_state_type state_ff, state_in;

   logic [KB-1:0]             kx_ff, kx_in, ky_ff, ky_in;
   logic [SLOT_BITS-1:0]      rslot_ff, rslot_in;
   logic [COL_BITS-1:0]       rcol_ff, rcol_in, x0_ff, x0_in;
   logic                      rvalid_ff;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   wws_meta_type              meta_ff, meta_ff_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]   value_ff;
   wws_meta_type              rsp_meta_ff;

   logic issue, acc_en, mul_en, use_bias, emit, out_free, last_issue, row_done;
   logic signed [ACC_BITS-1:0] op_a, op_b, add_out;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign row_done   = (kx_ff == kw - KB'(1));
   assign last_issue = row_done && (ky_ff == kh - KB'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SUM;
         ST_SUM:   if (last_issue) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_BIAS;
         ST_BIAS:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      issue    = 1'b0;
      acc_en   = 1'b0;
      mul_en   = 1'b0;
      use_bias = 1'b0;
      emit     = 1'b0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_SUM: begin
            issue  = 1'b1;
            acc_en = rvalid_ff;
         end
         ST_DRAIN: acc_en = rvalid_ff;
         ST_SCALE: mul_en = 1'b1;
         ST_BIAS: begin
            use_bias = 1'b1;
            emit     = out_free;
         end
         default:  busy = 1'b1;
      endcase
   end

   // the one adder: window sum, then scaled sum plus bias
   always_comb begin
      op_a    = use_bias ? ACC_BITS'(prod_ff >>> FRAC_BITS) : acc_ff;
      op_b    = use_bias ? ACC_BITS'(bias) : ACC_BITS'(rd_data);
      add_out = op_a + op_b;
   end

   always_comb begin
      kx_in      = kx_ff;
      ky_in      = ky_ff;
      rslot_in   = rslot_ff;
      rcol_in    = rcol_ff;
      x0_in      = x0_ff;
      meta_ff_in = meta_ff;
      acc_in     = acc_ff;
      if (start && !busy) begin
         kx_in      = '0;
         ky_in      = '0;
         rslot_in   = top_slot;
         rcol_in    = x0;
         x0_in      = x0;
         meta_ff_in = meta_in;
         acc_in     = '0;
      end else begin
         if (issue) begin
            if (row_done) begin
               kx_in   = '0;
               ky_in   = ky_ff + KB'(1);
               rcol_in = x0_ff;
               if (rslot_ff == SLOT_BITS'(MAX_KERNEL - 1)) begin
                  rslot_in = '0;
               end else begin
                  rslot_in = rslot_ff + SLOT_BITS'(1);
               end
            end else begin
               kx_in   = kx_ff + KB'(1);
               rcol_in = rcol_ff + COL_BITS'(1);
            end
         end
         if (acc_en) begin
            acc_in = add_out;
         end
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rvalid_ff    <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kx_ff    <= kx_in;
      ky_ff    <= ky_in;
      rslot_ff <= rslot_in;
      rcol_ff  <= rcol_in;
      x0_ff    <= x0_in;
      meta_ff  <= meta_ff_in;
      acc_ff   <= acc_in;
      if (mul_en) begin
         prod_ff <= weight * $signed(acc_ff[SUM_BITS-1:0]);
      end
      if (emit) begin
         value_ff    <= VAL_W'(add_out);
         rsp_meta_ff <= meta_ff;
      end
   end

   assign rd_en   = issue;
   assign rd_addr = {rslot_ff, rcol_ff};

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.value         = value_ff;
   assign rsp.out_col       = rsp_meta_ff.ox;
   assign rsp.out_row       = rsp_meta_ff.oy;
   assign rsp.last_of_plane = rsp_meta_ff.last;

endmodule

FILE: sv/weighted_window_subsample.sv
// top level of the weighted window subsampler (trainable average pooling)
//
//   channel  | direction | transfer carries
//   ---------+-----------+--------------------------------------------------
//   req      | in        | pixel, signed q8.8, raster order
//   rsp      | out       | value (8 fraction bits), out_col, out_row, last_of_plane
//   csr      | in        | apb register writes and reads, 8 registers at 4*i
//
// a pixel that completes no window leaves the window unit idle
// a pixel that completes a window stalls the input while the window unit does one
//   ram read per window pixel through a single adder, then drain, multiply, bias add
// a waiting result in the output register only stalls the final bias add step
// reset is synchronous; the row store needs no clearing, so the block is ready at once
module weighted_window_subsample import wws_pkg::*; #(
   parameter int MAX_KERNEL = 8,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int COL_BITS  = $clog2(MAX_WIDTH),
   localparam int KB        = $clog2(MAX_KERNEL + 1),
   localparam int SLOT_BITS = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
   input  logic              clock,
   input  logic              reset,
   wws_req_if.sink           req,
   wws_rsp_if.source         rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int AW    = SLOT_BITS + COL_BITS;
   localparam int DEPTH = 1 << AW;

   // configuration registers
   wws_geom_type        geom_ff, geom_in;
   logic [COEF_W-1:0]   weight_ff, weight_in;
   logic [COEF_W-1:0]   bias_ff, bias_in;
   wws_reg_type         reg_sel;
   logic                csr_wr, geom_clr;

   // window detection and arithmetic
   logic                 accept, win_hit, acc_busy;
   wws_meta_type         win_meta;
   logic [COL_BITS-1:0]  win_x0, wr_col;
   logic [SLOT_BITS-1:0] win_top, wr_slot;
   logic [KB-1:0]        kw, kh;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [PIX_W-1:0]     rd_data;

   // ---------------------------------------------------------------------------
   // apb register file: zero wait state, write lands in the access phase
   // ---------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign reg_sel    = wws_reg_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      geom_in   = geom_ff;
      weight_in = weight_ff;
      bias_in   = bias_ff;
      geom_clr  = 1'b0;
      if (csr_wr) begin
         unique case (reg_sel)
            REG_KERNEL_W: geom_in.kernel_w     = csr_pwdata[KREG_W-1:0];
            REG_KERNEL_H: geom_in.kernel_h     = csr_pwdata[KREG_W-1:0];
            REG_STRIDE_W: geom_in.stride_w     = csr_pwdata[KREG_W-1:0];
            REG_STRIDE_H: geom_in.stride_h     = csr_pwdata[KREG_W-1:0];
            REG_IMAGE_W:  geom_in.image_width  = csr_pwdata[DIM_REG_W-1:0];
            REG_IMAGE_H:  geom_in.image_height = csr_pwdata[DIM_REG_W-1:0];
            REG_WEIGHT:   weight_in            = csr_pwdata[COEF_W-1:0];
            REG_BIAS:     bias_in              = csr_pwdata[COEF_W-1:0];
            default:      geom_in              = geom_ff;
         endcase
         // any geometry change starts a fresh plane; weight and bias do not
         case (reg_sel) inside
            REG_KERNEL_W, REG_KERNEL_H, REG_STRIDE_W, REG_STRIDE_H,
            REG_IMAGE_W, REG_IMAGE_H: geom_clr = 1'b1;
            default:                  geom_clr = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.kernel_w     <= RST_KERNEL;
         geom_ff.kernel_h     <= RST_KERNEL;
         geom_ff.stride_w     <= RST_STRIDE;
         geom_ff.stride_h     <= RST_STRIDE;
         geom_ff.image_width  <= RST_DIM;
         geom_ff.image_height <= RST_DIM;
         weight_ff            <= RST_WEIGHT;
         bias_ff              <= RST_BIAS;
      end else begin
         geom_ff   <= geom_in;
         weight_ff <= weight_in;
         bias_ff   <= bias_in;
      end
   end

   // read back the raw register bits
   always_comb begin
      unique case (reg_sel)
         REG_KERNEL_W: csr_prdata = CSR_DW'(geom_ff.kernel_w);
         REG_KERNEL_H: csr_prdata = CSR_DW'(geom_ff.kernel_h);
         REG_STRIDE_W: csr_prdata = CSR_DW'(geom_ff.stride_w);
         REG_STRIDE_H: csr_prdata = CSR_DW'(geom_ff.stride_h);
         REG_IMAGE_W:  csr_prdata = CSR_DW'(geom_ff.image_width);
         REG_IMAGE_H:  csr_prdata = CSR_DW'(geom_ff.image_height);
         REG_WEIGHT:   csr_prdata = CSR_DW'(weight_ff);
         REG_BIAS:     csr_prdata = CSR_DW'(bias_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // input side: one pixel per transfer while the window unit is idle
   // ---------------------------------------------------------------------------
   assign req.ready = !acc_busy;
   assign accept    = req.valid && req.ready;

   // column, row, store slot and stride phase of the incoming pixel
   wws_geom #(
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_geom (
      .clock    (clock),
      .reset    (reset),
      .geom     (geom_ff),
      .geom_clr (geom_clr),
      .accept   (accept),
      .hit      (win_hit),
      .meta     (win_meta),
      .x0       (win_x0),
      .top_slot (win_top),
      .wr_slot  (wr_slot),
      .wr_col   (wr_col),
      .kw       (kw),
      .kh       (kh)
   );

   // row store: one slot per kernel row, addressed as {slot, column}
   wws_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_rows (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ({wr_slot, wr_col}),
      .wr_data (req.pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // window walk, scale and bias, result register towards rsp
   wws_accum #(
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && win_hit),
      .meta_in  (win_meta),
      .x0       (win_x0),
      .top_slot (win_top),
      .kw       (kw),
      .kh       (kh),
      .weight   (weight_ff),
      .bias     (bias_ff),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .busy     (acc_busy),
      .rsp      (rsp)
   );

   // ---------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------
   // a pixel closing a window must start the window walk
   a_hit_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && win_hit) |=> acc_busy)
      else $error("window hit did not start the accumulator");

   // the window walk only starts from a pixel transfer that closed a window
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(acc_busy) |-> $past(accept && win_hit))
      else $error("accumulator started without a window hit");

   // a new result only appears at the end of a window walk
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !$past(rsp.valid)) |-> $past(acc_busy))
      else $error("result appeared without window work");

endmodule
